// File: rtl/isfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_pkg
// Shared types and constants of the IMU serial frame parser.
// ----------------------------------------------------------------------------
package isfp_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_CODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_CODE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_CODE   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_CODE  = 2'd3;

   localparam logic [7:0] HEADER_CODE_RST = 8'h55;
   localparam logic [7:0] ACCEL_CODE_RST  = 8'h51;
   localparam logic [7:0] GYRO_CODE_RST   = 8'h52;
   localparam logic [7:0] ANGLE_CODE_RST  = 8'h53;

   localparam logic [7:0] SUM_SEED = 8'h55;

   localparam int unsigned STORED_BYTES = 8;
   localparam int unsigned STORE_W      = 8 * STORED_BYTES;

   localparam logic [1:0] KIND_ACCEL = 2'd0;
   localparam logic [1:0] KIND_GYRO  = 2'd1;
   localparam logic [1:0] KIND_ANGLE = 2'd2;

   typedef enum logic [1:0] {
      PH_HEAD = 2'd0,
      PH_TYPE = 2'd1,
      PH_DATA = 2'd2
   } isfp_phase_type;

   typedef struct packed {
      logic [7:0] header_code;
      logic [7:0] accel_code;
      logic [7:0] gyro_code;
      logic [7:0] angle_code;
   } isfp_codes_type;

endpackage

// File: rtl/isfp_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_csr
// Control registers: header byte and the three frame type codes.
// ----------------------------------------------------------------------------
module isfp_csr
   import isfp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output isfp_codes_type         codes
);

   isfp_codes_type codes_ff;
   isfp_codes_type codes_in;

   always_comb begin
      codes_in = codes_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HEADER_CODE: codes_in.header_code = csr_wdata;
            CSR_ACCEL_CODE:  codes_in.accel_code  = csr_wdata;
            CSR_GYRO_CODE:   codes_in.gyro_code   = csr_wdata;
            CSR_ANGLE_CODE:  codes_in.angle_code  = csr_wdata;
            default:         codes_in = codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.header_code <= HEADER_CODE_RST;
         codes_ff.accel_code  <= ACCEL_CODE_RST;
         codes_ff.gyro_code   <= GYRO_CODE_RST;
         codes_ff.angle_code  <= ANGLE_CODE_RST;
      end else begin
         codes_ff <= codes_in;
      end
   end

   assign codes = codes_ff;

endmodule

// File: rtl/imu_serial_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_core
// Byte-stream frame parser: header, type, payload, sum checksum.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_rx_byte, req_restart
//   rsp      out  rsp_valid/rsp_stall  rsp_frame_kind, rsp_word_a..d,
//                                      rsp_checksum_ok
//   csr      in   csr_wr_en            csr_index, csr_wdata
//
// One byte per cycle while req_stall is low; the frame result appears in
// the cycle after the checksum byte transfer, held in the output register.
// Synchronous reset returns to header search with default codes.
// req_stall rises only when a checksum byte is due and the output
// register still holds an untaken result.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_core
   import isfp_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = 8
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   input  logic                   req_restart,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_frame_kind,
   output logic signed [15:0]     rsp_word_a,
   output logic signed [15:0]     rsp_word_b,
   output logic signed [15:0]     rsp_word_c,
   output logic signed [15:0]     rsp_word_d,
   output logic                   rsp_checksum_ok,

   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES + 1);

   isfp_codes_type codes;

   isfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .codes     (codes)
   );

   isfp_phase_type     phase_ff, phase_in;
   logic [1:0]         kind_ff, kind_in;
   logic [IDX_W-1:0]   byte_index_ff, byte_index_in;
   logic [7:0]         sum_ff, sum_in;
   logic [STORE_W-1:0] payload_ff, payload_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff;
   logic [STORE_W-1:0] rsp_payload_ff;
   logic               rsp_ok_ff;

   logic               req_accept;
   logic               rsp_accept;
   logic               payload_full;
   logic               produce;
   logic [31:0]        index_wide;
   logic               index_stored;
   logic [2:0]         slot;

   assign payload_full = (phase_ff == PH_DATA) &&
                         (byte_index_ff == IDX_W'(PAYLOAD_BYTES));
   assign req_stall    = payload_full && rsp_valid_ff && rsp_stall;
   assign req_accept   = req_valid && !req_stall;
   assign rsp_accept   = rsp_valid_ff && !rsp_stall;
   assign produce      = req_accept && !req_restart && payload_full;

   assign index_wide   = 32'(byte_index_ff);
   assign index_stored = index_wide < 32'(STORED_BYTES);
   assign slot         = index_wide[2:0];

   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      byte_index_in = byte_index_ff;
      sum_in        = sum_ff;
      payload_in    = payload_ff;
      if (req_accept) begin
         if (req_restart) begin
            phase_in = PH_HEAD;
         end else begin
            case (phase_ff)
               PH_TYPE: begin
                  phase_in = PH_DATA;
                  if (req_rx_byte == codes.accel_code) begin
                     kind_in = KIND_ACCEL;
                  end else if (req_rx_byte == codes.angle_code) begin
                     kind_in = KIND_ANGLE;
                  end else if (req_rx_byte == codes.gyro_code) begin
                     kind_in = KIND_GYRO;
                  end else begin
                     phase_in = PH_HEAD;
                  end
                  if (phase_in == PH_DATA) begin
                     sum_in        = sum_ff + req_rx_byte;
                     byte_index_in = '0;
                     payload_in    = '0;
                  end
               end
               PH_DATA: begin
                  if (payload_full) begin
                     phase_in = PH_HEAD;
                  end else begin
                     for (int i = 0; i < STORED_BYTES; i++) begin
                        if (index_stored && slot == 3'(i)) begin
                           payload_in[8*i +: 8] = req_rx_byte;
                        end
                     end
                     sum_in        = sum_ff + req_rx_byte;
                     byte_index_in = byte_index_ff + IDX_W'(1);
                  end
               end
               default: begin
                  phase_in = PH_HEAD;
                  if (req_rx_byte == codes.header_code) begin
                     sum_in   = SUM_SEED;
                     phase_in = PH_TYPE;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEAD;
         kind_ff       <= KIND_ACCEL;
         byte_index_ff <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         byte_index_ff <= byte_index_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      if (produce) begin
         rsp_kind_ff    <= kind_ff;
         rsp_payload_ff <= payload_ff;
         rsp_ok_ff      <= (sum_ff == req_rx_byte);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_kind  = rsp_kind_ff;
   assign rsp_word_a      = rsp_payload_ff[15:0];
   assign rsp_word_b      = rsp_payload_ff[31:16];
   assign rsp_word_c      = rsp_payload_ff[47:32];
   assign rsp_word_d      = rsp_payload_ff[63:48];
   assign rsp_checksum_ok = rsp_ok_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(produce))
      else $error("result appeared without a checksum byte transfer");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> 32'(byte_index_ff) <= 32'(PAYLOAD_BYTES))
      else $error("payload index beyond frame length");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      produce |=> rsp_valid_ff && phase_ff == PH_HEAD)
      else $error("frame end did not load result and return to header search");

endmodule
